>>> sv/cvbf_pkg.sv
// Package of shared constants, codes and controller/datapath link types.
package cvbf_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MAX_EDGES    = 1024;
   localparam int VERT_W       = 8;
   localparam int VCOUNT_W     = 9;

   localparam logic [2:0] MODE_CLEAR   = 3'd0;
   localparam logic [2:0] MODE_ADD     = 3'd1;
   localparam logic [2:0] MODE_COMPUTE = 3'd2;
   localparam logic [2:0] MODE_READ    = 3'd3;
   localparam logic [2:0] MODE_QUERY   = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_VERTEX    = 2'd2;
   localparam logic [1:0] STATUS_INDEX     = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT,
      ST_SCAN_ISSUE,
      ST_SCAN_EDGE,
      ST_SCAN_DISC,
      ST_FINISH,
      ST_POP,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic accept;
      logic root_next;
      logic root_enter;
      logic edge_rd;
      logic disc_rd;
      logic low_update;
      logic descend;
      logic finish;
      logic pop;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic root_done;
      logic root_visited;
      logic scan_end;
      logic edge_skip;
      logic w_visited;
      logic sp_zero;
      logic rsp_free;
   } stat_type;

endpackage

>>> sv/cvbf_if.sv
// Channel interfaces for request, response and register write items.
interface cvbf_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] endpoint_a;
   logic [7:0] endpoint_b;
   logic [7:0] bridge_index;

   modport source (output valid, mode, endpoint_a, endpoint_b, bridge_index, input ready);
   modport sink (input valid, mode, endpoint_a, endpoint_b, bridge_index, output ready);
endinterface

interface cvbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  bridge_count;
   logic [7:0]  bridge_parent;
   logic [7:0]  bridge_child;
   logic        is_cut_vertex;
   logic [10:0] edge_total;

   modport source (output valid, status, bridge_count, bridge_parent, bridge_child,
                   is_cut_vertex, edge_total, input ready);
   modport sink (input valid, status, bridge_count, bridge_parent, bridge_child,
                 is_cut_vertex, edge_total, output ready);
endinterface

interface cvbf_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> sv/cvbf_ctrl.sv
// Controller state machine that sequences item handling and the search.
module cvbf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [2:0]          req_mode,
   input  cvbf_pkg::stat_type  stat,
   output logic                req_ready,
   output cvbf_pkg::cmd_type   cmd
);

   cvbf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cvbf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cvbf_pkg::ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in = (req_mode == cvbf_pkg::MODE_COMPUTE) ? cvbf_pkg::ST_ROOT
                                                               : cvbf_pkg::ST_RESPOND;
            end
         end
         cvbf_pkg::ST_ROOT: begin
            if (stat.root_done) begin
               state_in = cvbf_pkg::ST_RESPOND;
            end else if (stat.root_visited) begin
               cmd.root_next = 1'b1;
            end else begin
               cmd.root_enter = 1'b1;
               state_in = cvbf_pkg::ST_SCAN_ISSUE;
            end
         end
         cvbf_pkg::ST_SCAN_ISSUE: begin
            if (stat.scan_end) begin
               state_in = cvbf_pkg::ST_FINISH;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in = cvbf_pkg::ST_SCAN_EDGE;
            end
         end
         cvbf_pkg::ST_SCAN_EDGE: begin
            if (stat.edge_skip) begin
               state_in = cvbf_pkg::ST_SCAN_ISSUE;
            end else if (stat.w_visited) begin
               cmd.disc_rd = 1'b1;
               state_in = cvbf_pkg::ST_SCAN_DISC;
            end else begin
               cmd.descend = 1'b1;
               state_in = cvbf_pkg::ST_SCAN_ISSUE;
            end
         end
         cvbf_pkg::ST_SCAN_DISC: begin
            cmd.low_update = 1'b1;
            state_in = cvbf_pkg::ST_SCAN_ISSUE;
         end
         cvbf_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            if (stat.sp_zero) begin
               cmd.root_next = 1'b1;
               state_in = cvbf_pkg::ST_ROOT;
            end else begin
               state_in = cvbf_pkg::ST_POP;
            end
         end
         cvbf_pkg::ST_POP: begin
            cmd.pop = 1'b1;
            state_in = cvbf_pkg::ST_SCAN_ISSUE;
         end
         cvbf_pkg::ST_RESPOND: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = cvbf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cvbf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/cvbf_dp.sv
// Datapath with the edge store, search stack, discovery times, marks and result register.
module cvbf_dp #(
   parameter int MAX_EDGES = cvbf_pkg::MAX_EDGES
) (
   input  logic               clock,
   input  logic               reset,
   input  cvbf_pkg::cmd_type  cmd,
   output cvbf_pkg::stat_type stat,
   input  logic [8:0]         vertex_total,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_endpoint_a,
   input  logic [7:0]         req_endpoint_b,
   input  logic [7:0]         req_bridge_index,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_bridge_count,
   output logic [7:0]         rsp_bridge_parent,
   output logic [7:0]         rsp_bridge_child,
   output logic               rsp_is_cut_vertex,
   output logic [10:0]        rsp_edge_total
);

   localparam int ECNT_W = $clog2(MAX_EDGES + 1);
   localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NV     = cvbf_pkg::MAX_VERTICES;

   typedef struct packed {
      logic [7:0]        vertex;
      logic [EIDX_W-1:0] in_edge;
      logic              has_in;
      logic [ECNT_W-1:0] next_edge;
      logic [1:0]        children;
      logic [7:0]        low;
      logic [7:0]        disc;
   } frame_type;

   logic [7:0]   edge_a_mem [MAX_EDGES];
   logic [7:0]   edge_b_mem [MAX_EDGES];
   logic [7:0]   disc_mem   [NV];
   frame_type    stack_mem  [NV];
   logic [15:0]  bridge_mem [NV];

   frame_type         cur_ff;
   logic [7:0]        sp_ff;
   logic [8:0]        root_ff;
   logic [8:0]        visit_clock_ff;
   logic [8:0]        found_ff;
   logic [ECNT_W-1:0] stored_ff;
   logic [NV-1:0]     visited_ff;
   logic [NV-1:0]     cut_ff;
   logic [EIDX_W-1:0] edge_idx_ff;
   logic [2:0]        mode_ff;
   logic [7:0]        a_ff;
   logic [7:0]        idx_ff;
   logic [1:0]        add_status_ff;
   logic              rsp_valid_ff;

   logic [7:0]  ea_rd_ff, eb_rd_ff, disc_rd_ff;
   frame_type   stack_rd_ff;
   logic [15:0] bridge_rd_ff;

   logic [7:0]  w;
   logic        ea_in, eb_in;
   frame_type   push_frame, parent_next;
   logic        bridge_hit, cut_hit;
   logic        store_full, add_range_bad;
   logic        idx_bad, query_bad;

   assign ea_in = {1'b0, ea_rd_ff} < vertex_total;
   assign eb_in = {1'b0, eb_rd_ff} < vertex_total;
   assign w     = (ea_rd_ff == cur_ff.vertex) ? eb_rd_ff : ea_rd_ff;

   assign stat.root_done    = root_ff >= vertex_total;
   assign stat.root_visited = visited_ff[root_ff[7:0]];
   assign stat.scan_end     = cur_ff.next_edge >= stored_ff;
   assign stat.edge_skip    = !(ea_in && eb_in)
                            || (ea_rd_ff != cur_ff.vertex && eb_rd_ff != cur_ff.vertex)
                            || (cur_ff.has_in && edge_idx_ff == cur_ff.in_edge);
   assign stat.w_visited    = visited_ff[w];
   assign stat.sp_zero      = sp_ff == 8'd0;
   assign stat.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign store_full    = stored_ff >= ECNT_W'(MAX_EDGES);
   assign add_range_bad = {1'b0, req_endpoint_a} >= vertex_total
                       || {1'b0, req_endpoint_b} >= vertex_total;
   assign idx_bad       = {1'b0, idx_ff} >= found_ff;
   assign query_bad     = {1'b0, a_ff} >= vertex_total;

   // Frame pushed on descent carries the bumped (saturating) child count.
   always_comb begin
      push_frame = cur_ff;
      if (cur_ff.children != 2'd2) begin
         push_frame.children = cur_ff.children + 2'd1;
      end
   end

   // Merge of a finished child into its parent frame.
   always_comb begin
      parent_next = stack_rd_ff;
      if (cur_ff.low < stack_rd_ff.low) begin
         parent_next.low = cur_ff.low;
      end
   end
   assign bridge_hit = (cur_ff.low > stack_rd_ff.disc) && !found_ff[8];
   assign cut_hit    = (cur_ff.low >= stack_rd_ff.disc) && stack_rd_ff.has_in;

   // Edge store.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_mode == cvbf_pkg::MODE_ADD && !store_full && !add_range_bad) begin
         edge_a_mem[stored_ff[EIDX_W-1:0]] <= req_endpoint_a;
         edge_b_mem[stored_ff[EIDX_W-1:0]] <= req_endpoint_b;
      end
      if (cmd.edge_rd) begin
         ea_rd_ff <= edge_a_mem[cur_ff.next_edge[EIDX_W-1:0]];
         eb_rd_ff <= edge_b_mem[cur_ff.next_edge[EIDX_W-1:0]];
      end
   end

   // Discovery times.
   always_ff @(posedge clock) begin
      if (cmd.root_enter) begin
         disc_mem[root_ff[7:0]] <= visit_clock_ff[7:0];
      end else if (cmd.descend) begin
         disc_mem[w] <= visit_clock_ff[7:0];
      end
      if (cmd.disc_rd) begin
         disc_rd_ff <= disc_mem[w];
      end
   end

   // Search stack of ancestor frames.
   always_ff @(posedge clock) begin
      if (cmd.descend) begin
         stack_mem[sp_ff] <= push_frame;
      end
      if (cmd.finish) begin
         stack_rd_ff <= stack_mem[sp_ff - 8'd1];
      end
   end

   // Bridge list.
   always_ff @(posedge clock) begin
      if (cmd.pop && bridge_hit) begin
         bridge_mem[found_ff[7:0]] <= {stack_rd_ff.vertex, cur_ff.vertex};
      end
      if (cmd.accept) begin
         bridge_rd_ff <= bridge_mem[req_bridge_index];
      end
   end

   // Request fields and the current frame.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         a_ff    <= req_endpoint_a;
         idx_ff  <= req_bridge_index;
         if (store_full) begin
            add_status_ff <= cvbf_pkg::STATUS_FULL;
         end else if (add_range_bad) begin
            add_status_ff <= cvbf_pkg::STATUS_VERTEX;
         end else begin
            add_status_ff <= cvbf_pkg::STATUS_OK;
         end
      end
      if (cmd.root_enter) begin
         cur_ff.vertex    <= root_ff[7:0];
         cur_ff.in_edge   <= '0;
         cur_ff.has_in    <= 1'b0;
         cur_ff.next_edge <= '0;
         cur_ff.children  <= 2'd0;
         cur_ff.low       <= visit_clock_ff[7:0];
         cur_ff.disc      <= visit_clock_ff[7:0];
      end
      if (cmd.edge_rd) begin
         edge_idx_ff      <= cur_ff.next_edge[EIDX_W-1:0];
         cur_ff.next_edge <= cur_ff.next_edge + ECNT_W'(1);
      end
      if (cmd.low_update && disc_rd_ff < cur_ff.low) begin
         cur_ff.low <= disc_rd_ff;
      end
      if (cmd.descend) begin
         cur_ff.vertex    <= w;
         cur_ff.in_edge   <= edge_idx_ff;
         cur_ff.has_in    <= 1'b1;
         cur_ff.next_edge <= '0;
         cur_ff.children  <= 2'd0;
         cur_ff.low       <= visit_clock_ff[7:0];
         cur_ff.disc      <= visit_clock_ff[7:0];
      end
      if (cmd.pop) begin
         cur_ff <= parent_next;
      end
   end

   // Control counters and marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff      <= '0;
         found_ff       <= '0;
         visit_clock_ff <= '0;
         sp_ff          <= '0;
         root_ff        <= '0;
         visited_ff     <= '0;
         cut_ff         <= '0;
      end else begin
         if (cmd.accept) begin
            case (req_mode)
               cvbf_pkg::MODE_CLEAR: begin
                  stored_ff  <= '0;
                  found_ff   <= '0;
                  visited_ff <= '0;
                  cut_ff     <= '0;
               end
               cvbf_pkg::MODE_ADD: begin
                  if (!store_full && !add_range_bad) begin
                     stored_ff <= stored_ff + ECNT_W'(1);
                  end
               end
               cvbf_pkg::MODE_COMPUTE: begin
                  found_ff       <= '0;
                  visited_ff     <= '0;
                  cut_ff         <= '0;
                  visit_clock_ff <= '0;
                  root_ff        <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.root_next) begin
            root_ff <= root_ff + 9'd1;
         end
         if (cmd.root_enter) begin
            visited_ff[root_ff[7:0]] <= 1'b1;
            visit_clock_ff <= visit_clock_ff + 9'd1;
            sp_ff <= '0;
         end
         if (cmd.descend) begin
            visited_ff[w]  <= 1'b1;
            visit_clock_ff <= visit_clock_ff + 9'd1;
            sp_ff <= sp_ff + 8'd1;
         end
         if (cmd.finish) begin
            if (!cur_ff.has_in && cur_ff.children == 2'd2) begin
               cut_ff[cur_ff.vertex] <= 1'b1;
            end
            if (sp_ff != 8'd0) begin
               sp_ff <= sp_ff - 8'd1;
            end
         end
         if (cmd.pop) begin
            if (bridge_hit) begin
               found_ff <= found_ff + 9'd1;
            end
            if (cut_hit) begin
               cut_ff[stack_rd_ff.vertex] <= 1'b1;
            end
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_bridge_count  <= found_ff[7:0];
         rsp_edge_total    <= 11'(stored_ff);
         rsp_status        <= cvbf_pkg::STATUS_OK;
         rsp_bridge_parent <= 8'd0;
         rsp_bridge_child  <= 8'd0;
         rsp_is_cut_vertex <= 1'b0;
         case (mode_ff)
            cvbf_pkg::MODE_ADD: begin
               rsp_status <= add_status_ff;
            end
            cvbf_pkg::MODE_READ: begin
               if (idx_bad) begin
                  rsp_status <= cvbf_pkg::STATUS_INDEX;
               end else begin
                  rsp_bridge_parent <= bridge_rd_ff[15:8];
                  rsp_bridge_child  <= bridge_rd_ff[7:0];
               end
            end
            cvbf_pkg::MODE_QUERY: begin
               if (query_bad) begin
                  rsp_status <= cvbf_pkg::STATUS_VERTEX;
               end else begin
                  rsp_is_cut_vertex <= cut_ff[a_ff];
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/cut_vertex_and_bridge_finder.sv
// Top level of the cut vertex and bridge finder.
//
// The block takes items on the req_bus channel (valid/ready): clear graph,
// add edge, compute, read bridge and query vertex. Every item gives exactly
// one result item on rsp_bus with the status, the bridge count from the last
// compute, the stored edge count and the read bridge or cut flag.
// The csr_bus channel writes the vertex count; it is ready whenever reset is
// low. The user must write it only while no item is in flight; the block
// itself does not enforce this. A clear, add, read or query item passes
// through the respond state, where its result is loaded into the output
// register once that is free, and the controller then returns to idle.
// A compute item runs a depth-first search from each unseen vertex; every
// visited vertex scans the whole edge store one edge at a time, with an
// extra discovery-time read when the far end is already seen, so the edge
// scan sets the compute time.
// One item is handled at a time; a new item is taken once the previous
// result is in the output register, even if it has not been taken yet. A
// stalled receiver holds the result steady and holds off the next result.
// Reset empties the graph, clears the marks and bridge list and sets the
// vertex count to one. No clearing pass is needed.
module cut_vertex_and_bridge_finder #(
   parameter int MAX_EDGES = cvbf_pkg::MAX_EDGES
) (
   input logic       clock,
   input logic       reset,
   cvbf_req_if.sink   req_bus,
   cvbf_rsp_if.source rsp_bus,
   cvbf_csr_if.sink   csr_bus
);

   cvbf_pkg::cmd_type  cmd;
   cvbf_pkg::stat_type stat;

   logic [8:0] vertex_count_ff;
   logic [8:0] vertex_total;

   // The vertex count register accepts a write in every cycle outside reset.
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= 9'd1;
      end else if (csr_bus.valid) begin
         vertex_count_ff <= csr_bus.data;
      end
   end

   // Vertices in use, limited to what the stores can hold.
   assign vertex_total = (vertex_count_ff > 9'(cvbf_pkg::MAX_VERTICES))
                       ? 9'(cvbf_pkg::MAX_VERTICES) : vertex_count_ff;

   cvbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .stat      (stat),
      .req_ready (req_bus.ready),
      .cmd       (cmd)
   );

   cvbf_dp #(
      .MAX_EDGES (MAX_EDGES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .vertex_total      (vertex_total),
      .req_mode          (req_bus.mode),
      .req_endpoint_a    (req_bus.endpoint_a),
      .req_endpoint_b    (req_bus.endpoint_b),
      .req_bridge_index  (req_bus.bridge_index),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_bridge_count  (rsp_bus.bridge_count),
      .rsp_bridge_parent (rsp_bus.bridge_parent),
      .rsp_bridge_child  (rsp_bus.bridge_child),
      .rsp_is_cut_vertex (rsp_bus.is_cut_vertex),
      .rsp_edge_total    (rsp_bus.edge_total)
   );

endmodule

>>> sim/cvbf_checker.sv
// Checker that watches the channels, predicts cut vertices and bridges, and compares results.
module cvbf_checker (
   input  logic        clock,
   input  logic        reset,
   cvbf_req_if.sink    req_mon,
   cvbf_rsp_if.sink    rsp_mon,
   cvbf_csr_if.sink    csr_mon,
   output int          fail_count,
   output int          pending_count,
   output int          bridge_reads,
   output int          cut_hits
);

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  bridge_count;
      logic [7:0]  bridge_parent;
      logic [7:0]  bridge_child;
      logic        is_cut_vertex;
      logic [10:0] edge_total;
   } answer_type;

   typedef struct {
      int vtx;
      int in_edge;
      bit has_in;
      int next_edge;
      int kids;
   } frame_type;

   answer_type answer_q[$];
   int         vcount;
   logic [7:0] end_a[cvbf_pkg::MAX_EDGES];
   logic [7:0] end_b[cvbf_pkg::MAX_EDGES];
   int         edge_cnt;
   int         disc[cvbf_pkg::MAX_VERTICES];
   int         low[cvbf_pkg::MAX_VERTICES];
   bit         seen[cvbf_pkg::MAX_VERTICES];
   bit         cut[cvbf_pkg::MAX_VERTICES];
   frame_type  stk[cvbf_pkg::MAX_VERTICES];
   logic [7:0] br_par[cvbf_pkg::MAX_VERTICES];
   logic [7:0] br_chi[cvbf_pkg::MAX_VERTICES];
   int         br_cnt;
   int         tick;

   assign pending_count = answer_q.size();

   function automatic int live_vertices();
      return vcount < cvbf_pkg::MAX_VERTICES ? vcount : cvbf_pkg::MAX_VERTICES;
   endfunction

   function automatic void push_vertex(ref int depth, input int v, int e, bit has);
      stk[depth].vtx = v;
      stk[depth].in_edge = e;
      stk[depth].has_in = has;
      stk[depth].next_edge = 0;
      stk[depth].kids = 0;
      seen[v] = 1;
      disc[v] = tick;
      low[v] = tick;
      tick++;
      depth++;
   endfunction

   // Iterative low-link search from one root; edges are scanned in load order.
   function automatic void search_from(int root, int n);
      int depth, u, e, a, b, w, p;
      bit down, p_root;
      depth = 0;
      push_vertex(depth, root, 0, 0);
      while (depth > 0) begin
         u = stk[depth-1].vtx;
         down = 0;
         while (stk[depth-1].next_edge < edge_cnt) begin
            e = stk[depth-1].next_edge;
            stk[depth-1].next_edge++;
            a = int'(end_a[e]);
            b = int'(end_b[e]);
            if (a >= n || b >= n) continue;
            if (a == u) w = b;
            else if (b == u) w = a;
            else continue;
            if (stk[depth-1].has_in && e == stk[depth-1].in_edge) continue;
            if (seen[w]) begin
               if (disc[w] < low[u]) low[u] = disc[w];
            end else if (depth < cvbf_pkg::MAX_VERTICES) begin
               stk[depth-1].kids++;
               push_vertex(depth, w, e, 1);
               down = 1;
               break;
            end
         end
         if (down) continue;
         if (!stk[depth-1].has_in && stk[depth-1].kids > 1) cut[u] = 1;
         depth--;
         if (depth > 0) begin
            p = stk[depth-1].vtx;
            p_root = !stk[depth-1].has_in;
            if (low[u] < low[p]) low[p] = low[u];
            if (low[u] > disc[p] && br_cnt < cvbf_pkg::MAX_VERTICES) begin
               br_par[br_cnt] = p[7:0];
               br_chi[br_cnt] = u[7:0];
               br_cnt++;
            end
            if (low[u] >= disc[p] && !p_root) cut[p] = 1;
         end
      end
   endfunction

   function automatic answer_type predict_answer(logic [2:0] mode, logic [7:0] a,
                                                 logic [7:0] b, logic [7:0] idx);
      answer_type r;
      int n;
      r = '0;
      n = live_vertices();
      case (mode)
         cvbf_pkg::MODE_CLEAR: begin
            edge_cnt = 0;
            br_cnt = 0;
            seen = '{default: 0};
            cut = '{default: 0};
         end
         cvbf_pkg::MODE_ADD: begin
            if (edge_cnt >= cvbf_pkg::MAX_EDGES) r.status = cvbf_pkg::STATUS_FULL;
            else if (int'(a) >= n || int'(b) >= n) r.status = cvbf_pkg::STATUS_VERTEX;
            else begin
               end_a[edge_cnt] = a;
               end_b[edge_cnt] = b;
               edge_cnt++;
            end
         end
         cvbf_pkg::MODE_COMPUTE: begin
            seen = '{default: 0};
            cut = '{default: 0};
            br_cnt = 0;
            tick = 0;
            for (int v = 0; v < n; v++)
               if (!seen[v]) search_from(v, n);
         end
         cvbf_pkg::MODE_READ: begin
            if (int'(idx) >= br_cnt) r.status = cvbf_pkg::STATUS_INDEX;
            else begin
               r.bridge_parent = br_par[idx];
               r.bridge_child = br_chi[idx];
            end
         end
         cvbf_pkg::MODE_QUERY: begin
            if (int'(a) >= n) r.status = cvbf_pkg::STATUS_VERTEX;
            else r.is_cut_vertex = cut[a];
         end
         default: ;
      endcase
      r.bridge_count = br_cnt[7:0];
      r.edge_total = edge_cnt[10:0];
      return r;
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         vcount <= 1;
         edge_cnt = 0;
         br_cnt = 0;
         tick = 0;
         seen = '{default: 0};
         cut = '{default: 0};
         answer_q.delete();
         fail_count <= 0;
         bridge_reads <= 0;
         cut_hits <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) vcount <= int'(csr_mon.data);
         if (req_mon.valid && req_mon.ready)
            answer_q = {answer_q, predict_answer(req_mon.mode, req_mon.endpoint_a,
                                                 req_mon.endpoint_b, req_mon.bridge_index)};
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.status, rsp_mon.bridge_count, rsp_mon.bridge_parent,
                    rsp_mon.bridge_child, rsp_mon.is_cut_vertex, rsp_mon.edge_total};
            if (answer_q.size() == 0) begin
               if (fail_count < 10) $display("Result item with none expected: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, got);
                  fail_count <= fail_count + 1;
               end
               if (want.status == cvbf_pkg::STATUS_OK && want.bridge_child != want.bridge_parent)
                  bridge_reads <= bridge_reads + 1;
               if (want.is_cut_vertex) cut_hits <= cut_hits + 1;
            end
         end
      end
   end
endmodule

>>> sim/tb_top.sv
// Testbench top: drives graph-building and query items and gives the verdict.
module tb_top;

   logic clock = 0;
   logic reset = 1;
   int   cycle_count = 0;
   int   fail_count, pending_count, bridge_reads, cut_hits;
   int   send_idle = 0;   // percent chance the sender idles in a cycle
   int   recv_stall = 0;  // percent chance the receiver stalls in a cycle
   int   sent = 0;
   int   cur_vc = 1;      // vertex count that the testbench last wrote

   cvbf_req_if req_bus ();
   cvbf_rsp_if rsp_bus ();
   cvbf_csr_if csr_bus ();

   cut_vertex_and_bridge_finder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   cvbf_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus.sink),
      .rsp_mon       (rsp_bus.sink),
      .csr_mon       (csr_bus.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .bridge_reads  (bridge_reads),
      .cut_hits      (cut_hits)
   );

   always #6 clock = ~clock;

   // The limit allows for the slowest computes: the whole edge store scanned
   // from every vertex, several times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Timeout at cycle %0d", cycle_count);
         $display("cut_vertex_and_bridge_finder verification failed");
         $finish;
      end
   end

   // The receiver stalls at random, with the rate set by the current phase.
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= recv_stall);
   end

   // Send one item; idle cycles come before it at the phase's rate. Valid
   // stays high after acceptance until the next item or idle cycle.
   task automatic send_item(logic [2:0] mode, logic [7:0] a, logic [7:0] b,
                            logic [7:0] idx);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.endpoint_a <= a;
      req_bus.endpoint_b <= b;
      req_bus.bridge_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // Stop sending and wait until every expected result is back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // The register is only written while the block is idle.
   task automatic write_vertex_count(int vc);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data <= vc[8:0];
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      cur_vc = vc;
   endtask

   // Random endpoint: mostly inside the vertex range, sometimes anywhere.
   function automatic logic [7:0] pick_vertex();
      if (cur_vc > 0 && $urandom_range(9) != 0)
         return 8'($urandom_range(cur_vc > 256 ? 255 : cur_vc - 1));
      return 8'($urandom_range(255));
   endfunction

   // A session: clear, a small random graph, compute, then reads and queries
   // over the result, and sometimes one item with a random mode.
   task automatic graph_session(int edges);
      send_item(cvbf_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0);
      for (int k = 0; k < edges; k++)
         send_item(cvbf_pkg::MODE_ADD, pick_vertex(), pick_vertex(), 8'd0);
      send_item(cvbf_pkg::MODE_COMPUTE, 8'($urandom), 8'($urandom), 8'($urandom));
      for (int k = 0; k < 5; k++)
         send_item(cvbf_pkg::MODE_READ, 8'd0, 8'd0, 8'($urandom_range(5)));
      for (int k = 0; k < 3; k++) send_item(cvbf_pkg::MODE_QUERY, pick_vertex(), 8'd0, 8'd0);
      if ($urandom_range(3) == 0)
         send_item(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      req_bus.valid = 0;
      req_bus.mode = cvbf_pkg::MODE_CLEAR;
      req_bus.endpoint_a = 0;
      req_bus.endpoint_b = 0;
      req_bus.bridge_index = 0;
      csr_bus.valid = 0;
      csr_bus.data = 9'd1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: query and read before compute, then a path with a cycle
      // hanging off it, a parallel edge and a self-loop.
      send_item(cvbf_pkg::MODE_QUERY, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_QUERY, 8'd255, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_READ, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd1, 8'd0, 8'd0);
      write_vertex_count(6);
      send_item(cvbf_pkg::MODE_ADD, 8'd0, 8'd1, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd1, 8'd2, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd2, 8'd3, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd3, 8'd1, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd3, 8'd4, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd3, 8'd4, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd5, 8'd5, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd6, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_COMPUTE, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_READ, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_READ, 8'd0, 8'd0, 8'd255);
      send_item(cvbf_pkg::MODE_QUERY, 8'd1, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_QUERY, 8'd3, 8'd0, 8'd0);
      send_item(3'd7, 8'hff, 8'hff, 8'hff);
      send_item(3'd5, 8'd0, 8'd0, 8'd0);
      // Shrinking the count leaves stale edges that compute must skip.
      write_vertex_count(3);
      send_item(cvbf_pkg::MODE_COMPUTE, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_READ, 8'd0, 8'd0, 8'd0);
      write_vertex_count(0);
      send_item(cvbf_pkg::MODE_ADD, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_COMPUTE, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_QUERY, 8'd0, 8'd0, 8'd0);

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1) ? 61 : (ph == 3) ? 13 : 0;
         recv_stall = (ph == 2) ? 61 : (ph == 3) ? 13 : 0;
         write_vertex_count(ph == 0 ? 256 : int'($urandom_range(1, 12)));
         // Pause until every expected result has come back.
         if (ph == 2) drain();
         for (int s = 0; s < 4; s++) graph_session(int'($urandom_range(1, 10)));
      end

      // A count above the store size is limited to the 256 vertices the stores hold.
      send_idle = 0;
      recv_stall = 0;
      write_vertex_count(511);
      send_item(cvbf_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd255, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_ADD, 8'd0, 8'd128, 8'd0);
      send_item(cvbf_pkg::MODE_COMPUTE, 8'd0, 8'd0, 8'd0);
      send_item(cvbf_pkg::MODE_READ, 8'd0, 8'd0, 8'd1);
      send_item(cvbf_pkg::MODE_QUERY, 8'd0, 8'd0, 8'd0);

      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d items over directed graphs, four idling phases and a wide count;",
               sent);
      $display("%0d bridge reads and %0d cut vertex hits were predicted.", bridge_reads,
               cut_hits);
      if (fail_count == 0) $display("cut_vertex_and_bridge_finder verification clean");
      else $display("cut_vertex_and_bridge_finder verification failed");
      $finish;
   end
endmodule

>>> sim.f
sv/cvbf_pkg.sv
sv/cvbf_if.sv
sv/cvbf_ctrl.sv
sv/cvbf_dp.sv
sv/cut_vertex_and_bridge_finder.sv
sim/cvbf_checker.sv
sim/tb_top.sv
